FILE: rtl/uuid_tp_pkg.sv
`default_nettype none
package uuid_tp_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned CountW = 6;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  localparam logic [CountW-1:0] DIGITS_FULL = CountW'(32);

  // character classification from the decoder
  typedef struct packed {
    logic       is_dash;
    logic       is_open;
    logic       is_close;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // one result transaction
  typedef struct packed {
    logic             uuid_ok;
    logic [HalfW-1:0] value_high;
    logic [HalfW-1:0] value_low;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/uuid_tp_decode.sv
`default_nettype none
module uuid_tp_decode (
  input  wire logic [7:0]               char_code,
  output      uuid_tp_pkg::char_class_t cls
);
  import uuid_tp_pkg::*;

  logic is_num;
  logic is_alpha;

  // letters a-f / A-F: bit 5 is the case bit, low nibble 1..6
  assign is_num   = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h66)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h46));

  always_comb begin
    cls.is_dash  = (char_code == CH_DASH);
    cls.is_open  = (char_code == CH_OPEN);
    cls.is_close = (char_code == CH_CLOSE);
    cls.is_hex   = is_num || is_alpha;
    cls.nibble   = is_alpha ? (char_code[3:0] + 4'd9) : char_code[3:0];
  end

endmodule
`default_nettype wire

FILE: rtl/uuid_text_parser.sv
`default_nettype none
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------------
// char     | char_valid / char_ready     | char_code[7:0], is_final
// result   | result_valid / result_ready | uuid_ok, value_high[63:0], value_low[63:0]
//
// One character per clock while char_ready is high, back to back; parse state
// updates on the accepting edge. A final character loads its result on that edge;
// from an empty output result_valid rises the cycle after it. No gap between strings.
// Result register plus skid register: char_ready drops only while both are full.
// rst (sync, active high): parse state to start of string, both output entries empty.
module uuid_text_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           char_valid,
  output      logic                           char_ready,
  input  wire logic [7:0]                     char_code,
  input  wire logic                           is_final,
  output      logic                           result_valid,
  input  wire logic                           result_ready,
  output      logic                           uuid_ok,
  output      logic [uuid_tp_pkg::HalfW-1:0]  value_high,
  output      logic [uuid_tp_pkg::HalfW-1:0]  value_low
);
  import uuid_tp_pkg::*;

  // parse state
  logic              at_start,  at_start_next;
  logic              in_braces, in_braces_next;
  logic              failed,    failed_next;
  logic [CountW-1:0] digit_count, digit_count_next;
  logic [HalfW-1:0]  acc_high, acc_high_next;
  logic [HalfW-1:0]  acc_low,  acc_low_next;

  // output entries
  result_t out_q;
  result_t skid_q;
  result_t res_new;
  logic    skid_valid;

  char_class_t cls;
  logic        char_take;
  logic        final_take;
  logic        result_take;
  logic        str_ok;

  uuid_tp_decode u_decode (
    .char_code (char_code),
    .cls       (cls)
  );

  assign char_ready  = !skid_valid;
  assign char_take   = char_valid && char_ready;
  assign final_take  = char_take && is_final;
  assign result_take = result_valid && result_ready;

  // next parse state for the character on the port
  always_comb begin
    at_start_next    = 1'b0;
    in_braces_next   = in_braces;
    failed_next      = failed;
    digit_count_next = digit_count;
    acc_high_next    = acc_high;
    acc_low_next     = acc_low;

    priority if (at_start && cls.is_open) begin
      // lone '{' is not a UUID
      if (is_final) begin
        failed_next = 1'b1;
      end else begin
        in_braces_next = 1'b1;
      end
    end else if (is_final && in_braces) begin
      if (!cls.is_close) begin
        failed_next = 1'b1;
      end
    end else if (!cls.is_dash) begin
      if (!cls.is_hex || (digit_count >= DIGITS_FULL)) begin
        failed_next = 1'b1;
      end else if (!failed) begin
        acc_high_next    = {acc_high[HalfW-5:0], acc_low[HalfW-1 -: 4]};
        acc_low_next     = {acc_low[HalfW-5:0], cls.nibble};
        digit_count_next = digit_count + CountW'(1);
      end
    end else begin
      // dash: skipped
    end
  end

  assign str_ok = !failed_next && (digit_count_next == DIGITS_FULL);

  always_comb begin
    res_new.uuid_ok    = str_ok;
    res_new.value_high = str_ok ? acc_high_next : '0;
    res_new.value_low  = str_ok ? acc_low_next  : '0;
  end

  // parse state registers; a final character starts a fresh string
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start    <= 1'b1;
      in_braces   <= 1'b0;
      failed      <= 1'b0;
      digit_count <= '0;
      acc_high    <= '0;
      acc_low     <= '0;
    end else if (char_take) begin
      if (is_final) begin
        at_start    <= 1'b1;
        in_braces   <= 1'b0;
        failed      <= 1'b0;
        digit_count <= '0;
        acc_high    <= '0;
        acc_low     <= '0;
      end else begin
        at_start    <= at_start_next;
        in_braces   <= in_braces_next;
        failed      <= failed_next;
        digit_count <= digit_count_next;
        acc_high    <= acc_high_next;
        acc_low     <= acc_low_next;
      end
    end
  end

  // output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_take) begin
      // char_ready is low while skid holds, so no new final competes
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!final_take) begin
        result_valid <= 1'b0;
      end
    end else if (final_take) begin
      if (result_valid) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (result_take && skid_valid) begin
      out_q <= skid_q;
    end else if (final_take && (!result_valid || result_take)) begin
      out_q <= res_new;
    end
    if (final_take && result_valid && !result_take) begin
      skid_q <= res_new;
    end
  end

  assign uuid_ok    = out_q.uuid_ok;
  assign value_high = out_q.value_high;
  assign value_low  = out_q.value_low;

endmodule
`default_nettype wire

FILE: rtl/uuid_tp_checker.sv
`default_nettype none
module uuid_tp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           char_valid,
  input wire logic                           char_ready,
  input wire logic [7:0]                     char_code,
  input wire logic                           is_final,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic                           uuid_ok,
  input wire logic [uuid_tp_pkg::HalfW-1:0]  value_high,
  input wire logic [uuid_tp_pkg::HalfW-1:0]  value_low
);
  import uuid_tp_pkg::*;

  logic unused_in;
  assign unused_in = char_valid ^ is_final ^ (^char_code);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(uuid_ok) && $stable(value_high) && $stable(value_low))
    else $error("result changed while stalled");

  // failed parse carries a zero value
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !uuid_ok |-> (value_high == '0) && (value_low == '0))
    else $error("invalid result with nonzero value");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // input only stalls when a result is pending
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> char_ready)
    else $error("char_ready low with empty output");

endmodule

bind uuid_text_parser uuid_tp_checker u_checker (.*);
`default_nettype wire
